### hdl/date_alarm_table_unit_assert.svh
// Assertion macros for the alarm table, all on the rising edge of clk and
// disabled while rst_n is low.
`ifndef DATE_ALARM_TABLE_UNIT_ASSERT_SVH
`define DATE_ALARM_TABLE_UNIT_ASSERT_SVH

`define DATU_ASSERT_HOLDS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define DATU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/datu_pkg.sv
package datu_pkg;

    localparam logic [15:0] MS_PER_SECOND = 16'd1000;
    localparam logic [15:0] WINDOW_RESET  = 16'd1000;

    localparam logic REG_MATCH_WINDOW = 1'b0;

    typedef enum logic
    {
        FUNC_ADD  = 1'b0,
        FUNC_TICK = 1'b1
    } datu_func_t;

    typedef enum logic [2:0]
    {
        KIND_ADDED   = 3'd0,
        KIND_FULL    = 3'd1,
        KIND_FIRED   = 3'd2,
        KIND_EXPIRED = 3'd3,
        KIND_DONE    = 3'd4
    } datu_kind_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_READ,
        ST_EVAL
    } datu_state_t;

    typedef struct packed
    {
        logic [7:0] year;
        logic [3:0] month;
        logic [4:0] day_of_month;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [6:0] weekday_mask;
        logic [7:0] work_id;
    } alarm_entry_t;

    typedef struct packed
    {
        logic       func;
        logic [7:0] year;
        logic [3:0] month;
        logic [4:0] day_of_month;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [6:0] weekday_mask;
        logic [7:0] work_id;
    } in_item_t;

    typedef struct packed
    {
        logic [2:0] kind;
        logic [7:0] fired_work;
        logic       is_last;
    } out_item_t;

endpackage

### hdl/date_alarm_table_unit.sv
// Channel   Direction  Payload     Handshake
// in        input      in_item_t   in_valid / in_stall
// out       output     out_item_t  out_valid / out_stall
// apb       input      match_window_ms at byte address 0
//
// An add item writes the entry at the end of the table unless it is full; a tick walks the stored alarms
// with one table memory read and one evaluation per alarm.
// Alarms are compacted in the same pass: kept entries are written back at or behind the read pointer.
// Reset empties the table and sets the match window to 1000 ms.
// A stall on the output holds the walk on the alarm whose result is waiting.
module date_alarm_table_unit
    import datu_pkg::*;
#(
    parameter int ALARM_SLOTS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = $clog2(ALARM_SLOTS + 1);
    localparam int AW = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;

    datu_state_t  state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] rd_reg, rd_next;
    logic [CW-1:0] wr_reg, wr_next;
    alarm_entry_t cur_reg, cur_next;
    logic [15:0]  win_reg;
    logic         out_valid_reg, out_valid_next;
    out_item_t    out_data_reg, out_data_next;

    logic         ram_we;
    logic [AW-1:0] ram_waddr;
    alarm_entry_t ram_wdata;
    logic         ram_re;
    logic [AW-1:0] ram_raddr;
    alarm_entry_t ram_rdata;

    logic         can_load;
    logic         expired;
    logic         fires;
    logic [5:0]   sec_diff;
    logic [15:0]  diff_ms;
    alarm_entry_t in_entry;

    datu_ram #(
        .WIDTH ($bits(alarm_entry_t)),
        .DEPTH (ALARM_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MATCH_WINDOW) ? {16'b0, win_reg} : 32'b0;

    assign can_load = !out_valid_reg || !out_stall;
    assign in_stall = !((state_reg == ST_IDLE) && can_load);
    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

    assign in_entry = '{year: in_data.year, month: in_data.month,
                        day_of_month: in_data.day_of_month, hour: in_data.hour,
                        minute: in_data.minute, second: in_data.second,
                        weekday_mask: in_data.weekday_mask, work_id: in_data.work_id};

    assign expired = {cur_reg.year, cur_reg.month, cur_reg.day_of_month} >
                     {ram_rdata.year, ram_rdata.month, ram_rdata.day_of_month};
    assign sec_diff = cur_reg.second - ram_rdata.second;
    assign diff_ms  = 16'(sec_diff) * MS_PER_SECOND;
    assign fires = ({cur_reg.year, cur_reg.month, cur_reg.day_of_month} ==
                    {ram_rdata.year, ram_rdata.month, ram_rdata.day_of_month})
                   && (cur_reg.hour == ram_rdata.hour)
                   && (cur_reg.minute == ram_rdata.minute)
                   && (cur_reg.second >= ram_rdata.second)
                   && (diff_ms < win_reg);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rd_next        = rd_reg;
        wr_next        = wr_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = wr_reg[AW-1:0];
        ram_wdata      = ram_rdata;
        ram_re         = 1'b0;
        ram_raddr      = rd_reg[AW-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    if (in_data.func == FUNC_ADD)
                    begin
                        out_valid_next = 1'b1;
                        if (count_reg < CW'(ALARM_SLOTS))
                        begin
                            ram_we        = 1'b1;
                            ram_waddr     = count_reg[AW-1:0];
                            ram_wdata     = in_entry;
                            count_next    = CW'(count_reg + 1'b1);
                            out_data_next = '{kind: KIND_ADDED, fired_work: 8'd0, is_last: 1'b1};
                        end
                        else
                        begin
                            out_data_next = '{kind: KIND_FULL, fired_work: 8'd0, is_last: 1'b1};
                        end
                    end
                    else
                    begin
                        cur_next   = in_entry;
                        rd_next    = '0;
                        wr_next    = '0;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                if (rd_reg < count_reg)
                begin
                    ram_re     = 1'b1;
                    state_next = ST_EVAL;
                end
                else if (can_load)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{kind: KIND_DONE, fired_work: 8'd0, is_last: 1'b1};
                    count_next     = wr_reg;
                    state_next     = ST_IDLE;
                end
            end
            ST_EVAL:
            begin
                if ((ram_rdata.weekday_mask == 7'd0) && expired)
                begin
                    if (can_load)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = '{kind: KIND_EXPIRED, fired_work: ram_rdata.work_id,
                                          is_last: 1'b0};
                        rd_next        = CW'(rd_reg + 1'b1);
                        state_next     = ST_READ;
                    end
                end
                else if ((ram_rdata.weekday_mask != 7'd0) || !fires || can_load)
                begin
                    if ((ram_rdata.weekday_mask == 7'd0) && fires)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = '{kind: KIND_FIRED, fired_work: ram_rdata.work_id,
                                          is_last: 1'b0};
                    end
                    ram_we     = 1'b1;
                    wr_next    = CW'(wr_reg + 1'b1);
                    rd_next    = CW'(rd_reg + 1'b1);
                    state_next = ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rd_reg        <= '0;
            wr_reg        <= '0;
            out_valid_reg <= 1'b0;
            win_reg       <= WINDOW_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_reg        <= rd_next;
            wr_reg        <= wr_next;
            out_valid_reg <= out_valid_next;
            if (psel && penable && pwrite && pready && (paddr[2] == REG_MATCH_WINDOW))
            begin
                win_reg <= pwdata[15:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        out_data_reg <= out_data_next;
    end

`include "date_alarm_table_unit_assert.svh"

    `DATU_ASSERT_HOLDS(a_count_bound, count_reg <= CW'(ALARM_SLOTS), "alarm count above table size")
    `DATU_ASSERT_HOLDS(a_wr_behind_rd, (state_reg == ST_IDLE) || (wr_reg <= rd_reg), "compaction write passed read")
    `DATU_ASSERT_HOLDS(a_rd_bound, (state_reg == ST_IDLE) || (rd_reg <= count_reg), "walk read beyond table")
    `DATU_ASSERT_NEXT(a_tick_start, in_valid && !in_stall && (in_data.func == FUNC_TICK), (state_reg == ST_READ) && (rd_reg == '0) && (wr_reg == '0), "tick did not start walk")

endmodule

### hdl/datu_ram.sv
module datu_ram #(
    parameter int WIDTH = 49,
    parameter int DEPTH = 16
)
(
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
